### sv/wpl_pkg.sv
// ============================================================================
// wpl_pkg
// Shared types, codes and helpers for the words-per-line histogram block.
// ============================================================================
package wpl_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 6;
  localparam int WORDS_W  = 16;
  localparam int BIN_W    = 32;
  localparam int TOTAL_W  = 40;
  localparam int LINES_W  = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 1;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_DATA_W = WORDS_W + BIN_W + TOTAL_W + LINES_W;
  localparam int OUT_USER_W = 1;

  localparam int DEF_NUM_BINS = 64;

  // Op codes
  localparam logic [OP_W-1:0] OP_TEXT = 2'd0;
  localparam logic [OP_W-1:0] OP_END  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Result kinds
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LINES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINES  = 1'd1;

  localparam logic [WORDS_W-1:0] WORD_MAX  = '1;
  localparam logic [LINES_W-1:0] LINES_MAX = '1;

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_EXCL  = 8'h21;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_QUEST = 8'h3F;

  // Line-end or read request into the histogram stage
  typedef struct packed {
    logic               kind;
    logic [WORDS_W-1:0] words;
    logic [WORDS_W-1:0] key;    // word count, or bin index for a read
    logic [TOTAL_W-1:0] total;
    logic [LINES_W-1:0] lines;
  } req_t;

  // Result item
  typedef struct packed {
    logic               kind;
    logic [WORDS_W-1:0] words;
    logic [BIN_W-1:0]   bin_value;
    logic [TOTAL_W-1:0] total;
    logic [LINES_W-1:0] lines;
  } res_t;

  // Word separators
  function automatic logic is_delim(input logic [BYTE_W-1:0] b);
    logic d;
    case (b) inside
      CHAR_NUL, CHAR_NL, CHAR_SP, CHAR_EXCL, CHAR_COMMA,
      CHAR_DOT, CHAR_COLON, CHAR_SEMI, CHAR_QUEST: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### sv/wpl_ram.sv
// ============================================================================
// wpl_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ============================================================================
module wpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/wpl_line.sv
// ============================================================================
// wpl_line
// Word tokenizer and line bookkeeping: counts words per line, applies the
// skip / max line window and keeps the running totals.
// ============================================================================
module wpl_line (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wpl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  logic [wpl_pkg::OP_W-1:0]      op,
  input  logic [wpl_pkg::BYTE_W-1:0]    text_byte,
  input  logic [wpl_pkg::IDX_W-1:0]     bin_index,
  output logic                          req_valid,
  output wpl_pkg::req_t                 req
);
  import wpl_pkg::*;

  logic [CFG_W-1:0]   skip_lines;
  logic [CFG_W-1:0]   max_lines;

  logic               in_word, in_word_next;
  logic [WORDS_W-1:0] cur_words, cur_words_next;
  logic               has_bytes, has_bytes_next;
  logic [LINES_W-1:0] lines_skipped, lines_skipped_next;
  logic [LINES_W-1:0] lines_done, lines_done_next;
  logic [TOTAL_W-1:0] word_total, word_total_next;

  logic               delim;
  logic               closes_word;
  logic [WORDS_W-1:0] fin_words;
  logic               line_end;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_sat;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_lines <= '0;
      max_lines  <= LINES_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SKIP_LINES: skip_lines <= cfg_data;
        REG_MAX_LINES:  max_lines  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify and close words
  always_comb begin
    delim       = is_delim(text_byte);
    closes_word = in_word && ((op == OP_END) || delim);
    fin_words   = (closes_word && (cur_words != WORD_MAX)) ?
                  cur_words + WORDS_W'(1) : cur_words;
    line_end    = accept && (((op == OP_TEXT) && (text_byte == CHAR_NL)) ||
                             ((op == OP_END) && has_bytes));
    sum         = {1'b0, word_total} + {{(TOTAL_W+1-WORDS_W){1'b0}}, fin_words};
    total_sat   = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  end

  // Next state and request
  always_comb begin
    in_word_next       = in_word;
    cur_words_next     = cur_words;
    has_bytes_next     = has_bytes;
    lines_skipped_next = lines_skipped;
    lines_done_next    = lines_done;
    word_total_next    = word_total;
    req_valid          = 1'b0;
    req                = '0;

    if (accept) begin
      case (op)
        OP_TEXT: begin
          in_word_next   = !delim;
          cur_words_next = fin_words;
          has_bytes_next = 1'b1;
        end
        OP_READ: begin
          req_valid = 1'b1;
          req.kind  = KIND_READ;
          req.words = '0;
          req.key   = {{(WORDS_W-IDX_W){1'b0}}, bin_index};
          req.total = word_total;
          req.lines = lines_done;
        end
        default: ;
      endcase
    end

    if (line_end) begin
      in_word_next   = 1'b0;
      cur_words_next = '0;
      has_bytes_next = 1'b0;
      if (lines_skipped < skip_lines) begin
        lines_skipped_next = lines_skipped + LINES_W'(1);
      end else if (lines_done < max_lines) begin
        word_total_next = total_sat;
        lines_done_next = (lines_done == LINES_MAX) ? lines_done
                                                    : lines_done + LINES_W'(1);
        req_valid = 1'b1;
        req.kind  = KIND_LINE;
        req.words = fin_words;
        req.key   = fin_words;
        req.total = word_total_next;
        req.lines = lines_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word       <= 1'b0;
      cur_words     <= '0;
      has_bytes     <= 1'b0;
      lines_skipped <= '0;
      lines_done    <= '0;
      word_total    <= '0;
    end else begin
      in_word       <= in_word_next;
      cur_words     <= cur_words_next;
      has_bytes     <= has_bytes_next;
      lines_skipped <= lines_skipped_next;
      lines_done    <= lines_done_next;
      word_total    <= word_total_next;
    end
  end

`ifndef SYNTHESIS
  // An open word or counted words imply the line holds bytes
  a_open_line: assert property (@(posedge clk) disable iff (rst)
    ((cur_words != '0) || in_word) |-> has_bytes)
    else $error("word state set on an empty line");

  // A counted line leaves the line counter at the reported value
  a_lines_track: assert property (@(posedge clk) disable iff (rst)
    (req_valid && (req.kind == KIND_LINE)) |=> (lines_done == $past(req.lines)))
    else $error("line counter does not match reported count");
`endif

endmodule

### sv/wpl_hist.sv
// ============================================================================
// wpl_hist
// Histogram store: bin read-modify-write with forwarding, clear pass after
// reset, and the output register.
// ============================================================================
module wpl_hist #(
  parameter int NUM_BINS = wpl_pkg::DEF_NUM_BINS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  wpl_pkg::req_t req,
  output logic          take,
  output logic          out_valid,
  input  logic          out_ready,
  output wpl_pkg::res_t out
);
  import wpl_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam logic [AW-1:0] LAST = AW'(NUM_BINS - 1);

  logic          clr_active;
  logic [AW-1:0] clr_addr;

  logic          s1_valid;
  logic          s1_kind;
  logic [WORDS_W-1:0] s1_words;
  logic [AW-1:0] s1_addr;
  logic          s1_oob;
  logic [TOTAL_W-1:0] s1_total;
  logic [LINES_W-1:0] s1_lines;
  logic          fwd_hit;
  logic [BIN_W-1:0] fwd_data;

  logic [AW-1:0] req_addr;
  logic          req_oob;
  logic          s1_go;
  logic          s1_wr;
  logic [BIN_W-1:0] ram_rdata;
  logic [BIN_W-1:0] bin_cur;
  logic [BIN_W-1:0] bin_inc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BIN_W-1:0] ram_wdata;

  // Bin address: saturate word count to the top bin
  always_comb begin
    if (req.key >= WORDS_W'(NUM_BINS - 1)) begin
      req_addr = LAST;
    end else begin
      req_addr = req.key[AW-1:0];
    end
    req_oob = (req.key >= WORDS_W'(NUM_BINS));
  end

  // Stage control
  assign s1_go = !out_valid || out_ready;
  assign take  = !clr_active && (!s1_valid || s1_go);
  assign s1_wr = s1_valid && s1_go && (s1_kind == KIND_LINE);

  // Bin value, taking the write of the previous item when it hit this bin
  assign bin_cur = fwd_hit ? fwd_data : ram_rdata;
  assign bin_inc = (&bin_cur) ? bin_cur : bin_cur + BIN_W'(1);

  // Write port: clear pass or bin update
  always_comb begin
    ram_we    = clr_active || s1_wr;
    ram_waddr = clr_active ? clr_addr : s1_addr;
    ram_wdata = clr_active ? '0 : bin_inc;
  end

  wpl_ram #(
    .WIDTH (BIN_W),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req_valid),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      fwd_hit    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (clr_active) begin
        if (clr_addr == LAST) begin
          clr_active <= 1'b0;
        end else begin
          clr_addr <= clr_addr + AW'(1);
        end
      end

      if (req_valid) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_wr && (s1_addr == req_addr);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
        fwd_hit  <= 1'b0;
      end

      if (s1_valid && s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (req_valid) begin
      s1_kind  <= req.kind;
      s1_words <= req.words;
      s1_addr  <= req_addr;
      s1_oob   <= req_oob;
      s1_total <= req.total;
      s1_lines <= req.lines;
      fwd_data <= bin_inc;
    end
    if (s1_valid && s1_go) begin
      out.kind      <= s1_kind;
      out.words     <= s1_words;
      out.bin_value <= (s1_kind == KIND_LINE) ? bin_inc :
                       (s1_oob ? '0 : bin_cur);
      out.total     <= s1_total;
      out.lines     <= s1_lines;
    end
  end

`ifndef SYNTHESIS
  // Forwarded data only exists alongside an item in the stage
  a_fwd_item: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("forward flag without an item");

  // The clear pass covers every bin before it ends
  a_clr_full: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_active) |-> (clr_addr == LAST))
    else $error("clear pass ended early");

  // No item moves while the store is being cleared
  a_clr_idle: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> (!s1_valid && !out_valid && !req_valid))
    else $error("item in flight during clear pass");

  // An updated bin is never zero
  a_bin_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out.kind == KIND_LINE)) |-> (out.bin_value != '0))
    else $error("line result with a zero bin");
`endif

endmodule

### sv/words_per_line_histogram.sv
// ============================================================================
// words_per_line_histogram
// Words-per-line histogram over a byte stream, with running totals and
// bin read-back.
// ============================================================================
//
//  Channel   Dir  Handshake               Contents
//  s_axis    in   tvalid / tready         tuser: op; tdata: text_byte, bin_index
//  m_axis    out  tvalid / tready         tuser: kind; tdata: words, bin, totals
//  cfg       in   cfg_we                  cfg_index selects skip_lines/max_lines
//
//  One item per cycle sustained while s_axis_tready is high. A line end or
//  read looks up its bin in the histogram RAM (registered read) in the
//  lookup stage, and the result then lands in the output register.
//  After reset a clear pass writes all NUM_BINS bins, one per cycle; tready
//  stays low until the pass ends.
//  m_axis_tready low holds the output register and one item in the lookup
//  stage; outside the clear pass, s_axis_tready drops only when both are full.
//
module words_per_line_histogram #(
  parameter int NUM_BINS = wpl_pkg::DEF_NUM_BINS
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [wpl_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] text_byte, [13:8] bin_index
  input  logic [wpl_pkg::IN_USER_W-1:0]  s_axis_tuser,  // [1:0] op
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [wpl_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] line_word_count,
                                                        // [47:16] bin_value,
                                                        // [87:48] total_words,
                                                        // [111:88] lines_counted
  output logic [wpl_pkg::OUT_USER_W-1:0] m_axis_tuser,  // [0] kind
  // configuration
  input  logic                           cfg_we,
  input  logic [wpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpl_pkg::CFG_W-1:0]      cfg_data
);
  import wpl_pkg::*;

  logic  accept;
  logic  req_valid;
  req_t  req;
  res_t  res;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Tokenizer and line bookkeeping
  wpl_line u_line (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (s_axis_tuser[OP_W-1:0]),
    .text_byte (s_axis_tdata[BYTE_W-1:0]),
    .bin_index (s_axis_tdata[BYTE_W +: IDX_W]),
    .req_valid (req_valid),
    .req       (req)
  );

  // Histogram store and output register
  wpl_hist #(
    .NUM_BINS (NUM_BINS)
  ) u_hist (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .take      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out       (res)
  );

  // Result packing, first field lowest
  assign m_axis_tdata = {res.lines, res.total, res.bin_value, res.words};
  assign m_axis_tuser = res.kind;

endmodule
